/* design/mbf_pkg.sv */
// ----------------------------------------------------------------------------
// mbf_pkg: shared types and constants
// Widths, register indexes and lane helpers for the mipmap box filter.
// ----------------------------------------------------------------------------
package mbf_pkg;
	localparam int MaxSizeLog2 = 11;
	localparam int MaxComponents = 4;
	localparam int LvlW = 4;
	localparam int CntW = MaxSizeLog2;
	localparam int RpsDepth = (1 << MaxSizeLog2) - 1;
	localparam int RpsAw = MaxSizeLog2;
	localparam int PairW = 9;
	localparam int RpsW = PairW * MaxComponents;
	localparam int PixW = 8 * MaxComponents;

	localparam logic [1:0] RegWidthLog2 = 2'd0;
	localparam logic [1:0] RegHeightLog2 = 2'd1;
	localparam logic [1:0] RegCompCount = 2'd2;

	typedef logic [7:0] comp_t;
	typedef logic [PairW-1:0] pair_t;

	// Control handed from the sequencer to the component lanes.
	typedef struct packed {
		logic dx;
		logic dy;
	} lane_ctl_t;
endpackage

/* design/mbf_lane.sv */
// ----------------------------------------------------------------------------
// mbf_lane: one component lane
// Forms the horizontal pair sum and the 2x2 total of one byte component.
// ----------------------------------------------------------------------------
module mbf_lane (
	input  mbf_pkg::lane_ctl_t ctl,
	input  mbf_pkg::comp_t     cur,
	input  mbf_pkg::comp_t     left,
	input  mbf_pkg::pair_t     upper,
	output mbf_pkg::pair_t     pair,
	output mbf_pkg::comp_t     avg
);
	logic [9:0] tot;

	always_comb begin
		if (ctl.dx) begin
			pair = {1'b0, left} + {1'b0, cur};
		end else begin
			pair = {cur, 1'b0};
		end
		if (ctl.dy) begin
			tot = {1'b0, upper} + {1'b0, pair};
		end else begin
			tot = {pair, 1'b0};
		end
		avg = tot[9:2];
	end
endmodule

/* design/mipmap_box_filter_generator.sv */
// ----------------------------------------------------------------------------
// mipmap_box_filter_generator: streaming 2x2 box-filter mipmap generator
// Takes a level-0 raster and emits every lower level as its blocks complete.
// ----------------------------------------------------------------------------
// Usage:
//  - s_axis: one level-0 pixel per beat, raster order, tdata = comp0..comp3.
//  - m_axis: one filtered pixel per beat, tuser = level, tlast = run_end.
//  - cfg_*: write width_log2, height_log2, component_count while idle; a
//    write to any of these restarts the image at pixel (0,0). Buffers are kept.
//  - Each input pixel walks the levels, each level in a read state and then
//    a compute state. A pixel holds the input until its walk is done;
//    three quarters of the stream stop at level 0. The first result is
//    registered in the compute state of level 0, each further level after
//    another read and compute. The walk is set by the single-port row-sum
//    memory, read in the read state and consumed in the compute state.
//  - The four components go through four copies of the lane adder; the
//    result stage merges the lane averages into one output beat.
//  - A stalled receiver holds the output register and the walk; the input
//    is taken again only when the walk for the previous pixel is done.
//  - Reset clears counters and state; row sums and left pixels hold garbage
//    until written, which the raster order always does before reading.
// ----------------------------------------------------------------------------
module mipmap_box_filter_generator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [31:0] s_axis_tdata,   // comp0, comp1, comp2, comp3
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [55:0] m_axis_tdata,   // pos_x, pos_y, out0..out3, pad
	output logic        m_axis_tlast,   // run_end
	output logic [4:0]  m_axis_tuser,   // level, chain_done
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [3:0]  cfg_data
);
	localparam int Mx = mbf_pkg::MaxSizeLog2;
	localparam int Nc = mbf_pkg::MaxComponents;

	typedef enum logic [1:0] {ST_IDLE, ST_READ, ST_CALC} state_t;

	logic [3:0] wl_q, hl_q;
	logic [2:0] cc_q;
	logic [3:0] wl, hl, nlev;
	logic [2:0] ncomp;

	state_t state_q;
	logic [3:0] s_q;
	logic [mbf_pkg::CntW-1:0] x0_q, y0_q, x_q, y_q;
	logic [mbf_pkg::PixW-1:0] c_q;
	logic [mbf_pkg::PixW-1:0] left_q [Mx];
	logic [mbf_pkg::RpsW-1:0] rps_mem [mbf_pkg::RpsDepth];
	logic [mbf_pkg::RpsW-1:0] rps_rd_q;
	logic [mbf_pkg::RpsAw-1:0] idx;

	logic [3:0] pwl, phl;
	mbf_pkg::lane_ctl_t ctl;
	mbf_pkg::pair_t pair [Nc];
	mbf_pkg::comp_t avg [Nc];
	logic [mbf_pkg::RpsW-1:0] pair_pack;
	logic [mbf_pkg::PixW-1:0] avg_pack;
	logic [mbf_pkg::CntW-1:0] ox, oy;
	logic [Mx:0] base;
	logic [Mx-1:0] mask;
	logic [Mx:0] idx_w;
	logic out_free;
	logic brk;
	logic emit;

	assign wl = (wl_q > 4'(Mx)) ? 4'(Mx) : wl_q;
	assign hl = (hl_q > 4'(Mx)) ? 4'(Mx) : hl_q;
	assign nlev = (wl > hl) ? wl : hl;
	assign ncomp = (cc_q == 3'd0) ? 3'd1 : ((cc_q > 3'(Nc)) ? 3'(Nc) : cc_q);

	assign pwl = (wl > s_q) ? wl - s_q : 4'd0;
	assign phl = (hl > s_q) ? hl - s_q : 4'd0;
	assign ctl.dx = (pwl != 4'd0);
	assign ctl.dy = (phl != 4'd0);
	assign ox = ctl.dx ? (x_q >> 1) : x_q;
	assign oy = ctl.dy ? (y_q >> 1) : y_q;

	// Region of level s starts at 2^M - 2^(M-s); column masked to its width.
	assign base = (Mx+1)'(1 << Mx) - (Mx+1)'((Mx+1)'(1 << Mx) >> s_q);
	assign mask = Mx'(((Mx)'(1 << (Mx - 1))) >> s_q) - Mx'(1);
	assign idx_w = base + {1'b0, ox[Mx-1:0] & mask};
	assign idx = (idx_w >= (Mx+1)'(mbf_pkg::RpsDepth)) ?
		Mx'(mbf_pkg::RpsDepth - 1) : idx_w[Mx-1:0];

	for (genvar j = 0; j < Nc; j++) begin : g_lane
		mbf_lane u_lane (
			.ctl   (ctl),
			.cur   (c_q[8*j +: 8]),
			.left  (left_q[s_q][8*j +: 8]),
			.upper (rps_rd_q[9*j +: 9]),
			.pair  (pair[j]),
			.avg   (avg[j])
		);
		assign pair_pack[9*j +: 9] = pair[j];
		assign avg_pack[8*j +: 8] = avg[j];
	end

	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	// Walk stops at this level when it only parks a left pixel or a row sum.
	assign brk = (ctl.dx && !x_q[0]) || (ctl.dy && !y_q[0]);
	assign emit = (state_q == ST_CALC) && !brk && out_free;

	// Row-sum memory: read in READ, write in CALC.
	always_ff @(posedge clk) begin
		if (state_q == ST_READ) begin
			rps_rd_q <= rps_mem[idx];
		end
		if (state_q == ST_CALC && ctl.dy && !y_q[0] && !(ctl.dx && !x_q[0])) begin
			rps_mem[idx] <= pair_pack;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CALC && ctl.dx && !x_q[0]) begin
			left_q[s_q[3:0]] <= c_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wl_q <= '0;
			hl_q <= '0;
			cc_q <= 3'd4;
			state_q <= ST_IDLE;
			s_q <= '0;
			x0_q <= '0;
			y0_q <= '0;
			x_q <= '0;
			y_q <= '0;
			c_q <= '0;
			m_axis_tvalid <= 1'b0;
			m_axis_tdata <= '0;
			m_axis_tlast <= 1'b0;
			m_axis_tuser <= '0;
		end else begin
			// Load a new beat or drop the one just taken.
			if (emit) begin
				m_axis_tvalid <= 1'b1;
			end else if (m_axis_tready) begin
				m_axis_tvalid <= 1'b0;
			end
			if (cfg_we) begin
				case (cfg_index)
					mbf_pkg::RegWidthLog2: wl_q <= cfg_data;
					mbf_pkg::RegHeightLog2: hl_q <= cfg_data;
					mbf_pkg::RegCompCount: cc_q <= cfg_data[2:0];
					default: ;
				endcase
				if (cfg_index == mbf_pkg::RegWidthLog2 || cfg_index == mbf_pkg::RegHeightLog2
						|| cfg_index == mbf_pkg::RegCompCount) begin
					x0_q <= '0;
					y0_q <= '0;
				end
			end
			case (state_q)
				ST_IDLE: begin
					if (s_axis_tvalid) begin
						for (int j = 0; j < Nc; j++) begin
							c_q[8*j +: 8] <= (3'(j) < ncomp) ? s_axis_tdata[8*j +: 8] : 8'd0;
						end
						x_q <= x0_q;
						y_q <= y0_q;
						s_q <= '0;
						if (x0_q + 1'b1 >= (mbf_pkg::CntW+1)'(1 << wl)) begin
							x0_q <= '0;
							y0_q <= (y0_q + 1'b1 >= (mbf_pkg::CntW+1)'(1 << hl)) ?
								'0 : y0_q + 1'b1;
						end else begin
							x0_q <= x0_q + 1'b1;
						end
						state_q <= (nlev == 4'd0) ? ST_IDLE : ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_CALC;
				end
				ST_CALC: begin
					if (brk) begin
						state_q <= ST_IDLE;
					end else if (out_free) begin
						c_q <= avg_pack;
						x_q <= ox;
						y_q <= oy;
						s_q <= s_q + 1'b1;
						m_axis_tdata <= {4'd0, avg_pack, oy[9:0], ox[9:0]};
						m_axis_tuser <= {(s_q + 4'd1 == nlev), s_q + 4'd1};
						// Last emission when the top level is reached or the
						// next level will only latch its pending data.
						m_axis_tlast <= (s_q + 4'd1 == nlev)
							|| (((wl > s_q + 4'd1) && !ox[0])
							|| ((hl > s_q + 4'd1) && !oy[0]
								&& !((wl > s_q + 4'd1) && !ox[0])));
						state_q <= (s_q + 4'd1 == nlev) ? ST_IDLE : ST_READ;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTH
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> !s_axis_tready) else $error("ready while busy");
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tuser[3:0] != 4'd0)) else $error("level zero");
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser[4]) |-> m_axis_tlast) else $error("done not last");
`endif
endmodule
